### src/spds_pkg.sv
package spds_pkg;

  localparam int PRESCALE_STEPS = 8;
  localparam int EXP_W          = 3;
  localparam int DATA_W         = 32;
  localparam int FREQ_W         = 31;
  localparam int CNT_W          = 8;
  localparam int MUL_W          = 16;   // (divider + 2) << exponent
  localparam int DIV_W          = 8;
  localparam int REM_W          = 64;
  localparam int QUO_W          = 32;

  // quotient bits resolved by each cell row
  localparam int SEARCH_CELLS = 10;
  localparam int FREQ_CELLS   = 32;
  localparam int DELAY_CELLS  = 10;
  localparam int Q_W          = 10;
  localparam int DELAY_LANES  = 3;

  localparam logic [REM_W-1:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [REM_W-1:0] NS_DEN     = NS_PER_SEC << (DELAY_CELLS - 1);

  typedef enum logic [1:0] {
    REG_SRC_CLK  = 2'd0,
    REG_CS_SCK   = 2'd1,
    REG_SCK_CS   = 2'd2,
    REG_XFER_GAP = 2'd3
  } reg_idx_t;

  // one restoring division step: partial remainder, aligned divisor, quotient so far
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } div_t;

  // per-exponent candidates carried through the frequency divide
  typedef struct packed {
    logic [PRESCALE_STEPS-1:0][DIV_W-1:0] dvd;
    logic [PRESCALE_STEPS-1:0][MUL_W-1:0] mul;
    logic [PRESCALE_STEPS-1:0]            ok;
  } cand_t;

  // chosen setting carried through the delay divides
  typedef struct packed {
    logic [EXP_W-1:0]       ex;
    logic [DIV_W-1:0]       dvd;
    logic [FREQ_W-1:0]      freq;
    logic [DELAY_LANES-1:0] zero;
  } pick_t;

  // divider field from q = floor((src-1)/(req<<e)), saturated reading
  function automatic logic [DIV_W-1:0] div_of(input logic [Q_W-1:0] q);
    logic [DIV_W-1:0] d;
    if (q >= Q_W'(256)) d = 8'd255;
    else if (q == '0)   d = '0;
    else                d = DIV_W'(q - Q_W'(1));
    return d;
  endfunction

  // cycle count from q = floor((prod-1)/1e9); floor of two when two_floor
  function automatic logic [CNT_W-1:0] cnt_of(input logic [Q_W-1:0] q, input logic zero,
                                              input logic two_floor);
    logic [CNT_W-1:0] c;
    if (zero)                   c = '0;
    else if (!two_floor)        c = (q >= Q_W'(255)) ? 8'd255 : CNT_W'(q);
    else if (q == '0)           c = '0;
    else if (q >= Q_W'(256))    c = 8'd255;
    else                        c = CNT_W'(q - Q_W'(1));
    return c;
  endfunction

endpackage

### src/sck_prescaler_divider_search.sv
// Serial clock prescaler / divider search with delay conversion.
//
// Request channel: drive in_desired_freq with start high; the item is taken
// at any rising edge where start is high and busy is low. busy never rises,
// so a new request may be issued every clock cycle.
// Result channel: out_valid strobes for one cycle with the chosen prescale
// exponent, divider, achieved frequency and the three delay counts. The
// receiver cannot hold results off; they appear in request order.
// Throughput: one item per cycle. The pipeline is built from three rows
// of division cells: 10 cells per exponent lane for the divider search,
// 32 cells for the achieved frequency and 10 cells per delay, plus the
// multiply and select stages between them.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (source
// clock, select-to-clock, clock-to-select and inter-transfer delays). Write
// only while no item is in flight.
// Reset: synchronous, active low; clears the registers and in-flight items.
module sck_prescaler_divider_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_desired_freq,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_prescale_exp,
  output logic [7:0]  out_sck_divider,
  output logic [30:0] out_achieved_freq,
  output logic [7:0]  out_cs_to_sck_count,
  output logic [7:0]  out_sck_to_cs_count,
  output logic [7:0]  out_between_transfer_count
);

  localparam int NE   = spds_pkg::PRESCALE_STEPS;
  localparam int S1   = spds_pkg::SEARCH_CELLS + 1;
  localparam int S4   = S1 + 3;
  localparam int S5   = S4 + spds_pkg::FREQ_CELLS + 1;
  localparam int S8   = S5 + 3;
  localparam int S9   = S8 + spds_pkg::DELAY_CELLS + 1;
  localparam int LAT  = S9 + 1;

  // configuration registers
  logic [31:0] src_r, cs_sck_r, sck_cs_r, xfer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r    <= '0;
      cs_sck_r <= '0;
      sck_cs_r <= '0;
      xfer_r   <= '0;
    end else if (cfg_we) begin
      case (spds_pkg::reg_idx_t'(cfg_index))
        spds_pkg::REG_SRC_CLK:  src_r    <= cfg_wdata;
        spds_pkg::REG_CS_SCK:   cs_sck_r <= cfg_wdata;
        spds_pkg::REG_SCK_CS:   sck_cs_r <= cfg_wdata;
        spds_pkg::REG_XFER_GAP: xfer_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the pipeline never stalls
  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // valid bit per pipeline position
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  // ---------------- divider search: one cell row per exponent ----------------
  logic [31:0] req0_r;
  logic [31:0] req_dl_r [spds_pkg::SEARCH_CELLS];
  spds_pkg::div_t srch_c [NE][spds_pkg::SEARCH_CELLS+1];

  always_ff @(posedge clk) begin
    if (acc) req0_r <= in_desired_freq;
    req_dl_r[0] <= req0_r;
    for (int j = 1; j < spds_pkg::SEARCH_CELLS; j++) req_dl_r[j] <= req_dl_r[j-1];
  end

  // remainder starts at src-1 so the quotient plus one is the ceiling
  for (genvar e = 0; e < NE; e++) begin : g_srch
    assign srch_c[e][0].rem = spds_pkg::REM_W'(src_r - 32'd1);
    assign srch_c[e][0].den = spds_pkg::REM_W'(req0_r) << (e + spds_pkg::SEARCH_CELLS - 1);
    assign srch_c[e][0].quo = '0;
    for (genvar k = 0; k < spds_pkg::SEARCH_CELLS; k++) begin : g_cell
      spds_div_cell u_cell (.clk(clk), .d_in(srch_c[e][k]), .d_out(srch_c[e][k+1]));
    end
  end

  // S1: divider and total division per exponent
  logic [7:0]  d1_r [NE];
  logic [15:0] m1_r [NE];
  logic [31:0] req1_r;
  logic [31:0] req_s;
  logic [7:0]  d1_nxt [NE];

  assign req_s = req_dl_r[spds_pkg::SEARCH_CELLS-1];

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      // a dead source clock gives divider 0 unless the request is zero too
      if (src_r == '0 && req_s != '0) d1_nxt[e] = '0;
      else d1_nxt[e] = spds_pkg::div_of(srch_c[e][spds_pkg::SEARCH_CELLS].quo[spds_pkg::Q_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      d1_r[e] <= d1_nxt[e];
      m1_r[e] <= (spds_pkg::MUL_W'(d1_nxt[e]) + 16'd2) << e;
    end
    req1_r <= req_s;
  end

  // S2: bound product; S3: candidate fits when src < M * (req + 1)
  logic [48:0] prod2_r [NE];
  logic [7:0]  d2_r [NE], d3_r [NE];
  logic [15:0] m2_r [NE], m3_r [NE];
  logic [NE-1:0] ok3_r;

  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      prod2_r[e] <= 49'(m1_r[e]) * (49'(req1_r) + 49'd1);
      d2_r[e]    <= d1_r[e];
      m2_r[e]    <= m1_r[e];
      ok3_r[e]   <= 49'(src_r) < prod2_r[e];
      d3_r[e]    <= d2_r[e];
      m3_r[e]    <= m2_r[e];
    end
  end

  // S4: smallest total division among fitting candidates gives the best frequency
  logic [15:0]       mmin_nxt, mmin4_r;
  logic              any_nxt, any4_r;
  spds_pkg::cand_t   cand4_r;

  always_comb begin
    mmin_nxt = '0;
    any_nxt  = 1'b0;
    for (int e = 0; e < NE; e++) begin
      if (ok3_r[e] && (!any_nxt || m3_r[e] < mmin_nxt)) begin
        mmin_nxt = m3_r[e];
        any_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mmin4_r <= mmin_nxt;
    any4_r  <= any_nxt;
    for (int e = 0; e < NE; e++) begin
      cand4_r.dvd[e] <= d3_r[e];
      cand4_r.mul[e] <= m3_r[e];
      cand4_r.ok[e]  <= ok3_r[e];
    end
  end

  // ---------------- achieved frequency: src / Mmin ----------------
  spds_pkg::div_t  freq_c [spds_pkg::FREQ_CELLS+1];
  spds_pkg::cand_t cand_dl_r [spds_pkg::FREQ_CELLS];
  logic            any_dl_r [spds_pkg::FREQ_CELLS];

  assign freq_c[0].rem = spds_pkg::REM_W'(src_r);
  assign freq_c[0].den = spds_pkg::REM_W'(mmin4_r) << (spds_pkg::FREQ_CELLS - 1);
  assign freq_c[0].quo = '0;

  for (genvar k = 0; k < spds_pkg::FREQ_CELLS; k++) begin : g_freq
    spds_div_cell u_cell (.clk(clk), .d_in(freq_c[k]), .d_out(freq_c[k+1]));
  end

  always_ff @(posedge clk) begin
    cand_dl_r[0] <= cand4_r;
    any_dl_r[0]  <= any4_r;
    for (int j = 1; j < spds_pkg::FREQ_CELLS; j++) begin
      cand_dl_r[j] <= cand_dl_r[j-1];
      any_dl_r[j]  <= any_dl_r[j-1];
    end
  end

  // S5..S7: lowest exponent whose frequency equals the best one
  logic [30:0]     f5_r, f6_r;
  spds_pkg::cand_t cand5_r, cand6_r;
  logic            any5_r, any6_r;
  logic [46:0]     tie6_r [NE];
  spds_pkg::pick_t pick_nxt, pick7_r;
  logic            found;

  always_ff @(posedge clk) begin
    f5_r    <= freq_c[spds_pkg::FREQ_CELLS].quo[spds_pkg::FREQ_W-1:0];
    cand5_r <= cand_dl_r[spds_pkg::FREQ_CELLS-1];
    any5_r  <= any_dl_r[spds_pkg::FREQ_CELLS-1];
    for (int e = 0; e < NE; e++) tie6_r[e] <= 47'(cand5_r.mul[e]) * 47'(f5_r);
    f6_r    <= f5_r;
    cand6_r <= cand5_r;
    any6_r  <= any5_r;
  end

  always_comb begin
    pick_nxt = '0;
    found    = 1'b0;
    for (int e = 0; e < NE; e++) begin
      if (!found && any6_r && cand6_r.ok[e] && tie6_r[e] <= 47'(src_r)) begin
        found         = 1'b1;
        pick_nxt.ex   = spds_pkg::EXP_W'(e);
        pick_nxt.dvd  = cand6_r.dvd[e];
        pick_nxt.freq = f6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    pick7_r <= pick_nxt;
  end

  // S8: delays in nanoseconds times prescaled clock
  logic [31:0]     pclk;
  logic [63:0]     prod8_r [spds_pkg::DELAY_LANES];
  spds_pkg::pick_t pick8_r;
  logic [31:0]     ns [spds_pkg::DELAY_LANES];

  assign pclk  = src_r >> pick7_r.ex;
  assign ns[0] = cs_sck_r;
  assign ns[1] = sck_cs_r;
  assign ns[2] = xfer_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < spds_pkg::DELAY_LANES; i++) prod8_r[i] <= 64'(pclk) * 64'(ns[i]);
    pick8_r <= pick7_r;
  end

  // ---------------- delay counts: ceil(prod / 1e9) ----------------
  spds_pkg::div_t  dly_c [spds_pkg::DELAY_LANES][spds_pkg::DELAY_CELLS+1];
  spds_pkg::pick_t pick_dl_r [spds_pkg::DELAY_CELLS];
  spds_pkg::pick_t pick8_z;

  always_comb begin
    pick8_z = pick8_r;
    for (int i = 0; i < spds_pkg::DELAY_LANES; i++) pick8_z.zero[i] = (prod8_r[i] == '0);
  end

  for (genvar i = 0; i < spds_pkg::DELAY_LANES; i++) begin : g_dly
    assign dly_c[i][0].rem = prod8_r[i] - 64'd1;
    assign dly_c[i][0].den = spds_pkg::NS_DEN;
    assign dly_c[i][0].quo = '0;
    for (genvar k = 0; k < spds_pkg::DELAY_CELLS; k++) begin : g_cell
      spds_div_cell u_cell (.clk(clk), .d_in(dly_c[i][k]), .d_out(dly_c[i][k+1]));
    end
  end

  always_ff @(posedge clk) begin
    pick_dl_r[0] <= pick8_z;
    for (int j = 1; j < spds_pkg::DELAY_CELLS; j++) pick_dl_r[j] <= pick_dl_r[j-1];
  end

  // S9: result registers
  spds_pkg::pick_t pick_e;
  logic [9:0]      q_cs, q_sc, q_xf;

  assign pick_e = pick_dl_r[spds_pkg::DELAY_CELLS-1];
  assign q_cs   = dly_c[0][spds_pkg::DELAY_CELLS].quo[spds_pkg::Q_W-1:0];
  assign q_sc   = dly_c[1][spds_pkg::DELAY_CELLS].quo[spds_pkg::Q_W-1:0];
  assign q_xf   = dly_c[2][spds_pkg::DELAY_CELLS].quo[spds_pkg::Q_W-1:0];

  logic [2:0]  ex_r;
  logic [7:0]  div_r, cs_r, sc_r, xf_r;
  logic [30:0] freq_r;

  always_ff @(posedge clk) begin
    ex_r   <= pick_e.ex;
    div_r  <= pick_e.dvd;
    freq_r <= pick_e.freq;
    cs_r   <= spds_pkg::cnt_of(q_cs, pick_e.zero[0], 1'b0);
    sc_r   <= spds_pkg::cnt_of(q_sc, pick_e.zero[1], 1'b0);
    xf_r   <= spds_pkg::cnt_of(q_xf, pick_e.zero[2], 1'b1);
  end

  assign out_valid                  = vld_r[LAT-1];
  assign out_prescale_exp           = ex_r;
  assign out_sck_divider            = div_r;
  assign out_achieved_freq          = freq_r;
  assign out_cs_to_sck_count        = cs_r;
  assign out_sck_to_cs_count        = sc_r;
  assign out_between_transfer_count = xf_r;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("result did not appear at fixed latency");

  a_min_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S4] && any4_r) |-> (mmin4_r >= 16'd2))
    else $error("best total division below two");

  a_dead_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && src_r == '0) |-> (out_achieved_freq == '0 && out_cs_to_sck_count == '0 &&
      out_sck_to_cs_count == '0 && out_between_transfer_count == '0))
    else $error("nonzero result with stopped source clock");

endmodule

### src/spds_div_cell.sv
module spds_div_cell (
  input  logic               clk,
  input  spds_pkg::div_t     d_in,
  output spds_pkg::div_t     d_out
);

  spds_pkg::div_t cell_r;
  spds_pkg::div_t cell_nxt;
  logic           ge;

  always_comb begin
    ge           = (d_in.rem >= d_in.den);
    cell_nxt.rem = ge ? (d_in.rem - d_in.den) : d_in.rem;
    cell_nxt.den = d_in.den >> 1;
    cell_nxt.quo = {d_in.quo[spds_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign d_out = cell_r;

endmodule

### tb/sck_prescaler_divider_search_tb.sv
`timescale 1ns / 100ps

module sck_prescaler_divider_search_tb;

  // One result item, at the widths of the result ports.
  typedef struct packed {
    logic [2:0]  ex;
    logic [7:0]  dvd;
    logic [30:0] freq;
    logic [7:0]  cs_sck;
    logic [7:0]  sck_cs;
    logic [7:0]  gap;
  } clk_setting_t;

  // One row of the directed table: register values, request, and an
  // expectation that is typed in only when has_known is set.
  typedef struct {
    logic [31:0]  src;
    logic [31:0]  d_cs_sck;
    logic [31:0]  d_sck_cs;
    logic [31:0]  d_gap;
    logic [31:0]  req;
    bit           has_known;
    clk_setting_t known;
  } directed_row_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [63:0] NSEC = 64'd1000000000;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_desired_freq;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        out_valid;
  logic [2:0]  out_prescale_exp;
  logic [7:0]  out_sck_divider;
  logic [30:0] out_achieved_freq;
  logic [7:0]  out_cs_to_sck_count;
  logic [7:0]  out_sck_to_cs_count;
  logic [7:0]  out_between_transfer_count;

  // Shadow copy of the configuration registers.
  logic [31:0] src_hz, cs_sck_ns, sck_cs_ns, gap_ns;

  clk_setting_t pending_settings[$];
  clk_setting_t next_known;
  bit           next_has_known;
  int           mismatches;
  int           stall_cycles;
  bit           idle_enabled;

  sck_prescaler_divider_search DUT (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .start                      (start),
    .busy                       (busy),
    .in_desired_freq            (in_desired_freq),
    .cfg_we                     (cfg_we),
    .cfg_index                  (cfg_index),
    .cfg_wdata                  (cfg_wdata),
    .out_valid                  (out_valid),
    .out_prescale_exp           (out_prescale_exp),
    .out_sck_divider            (out_sck_divider),
    .out_achieved_freq          (out_achieved_freq),
    .out_cs_to_sck_count        (out_cs_to_sck_count),
    .out_sck_to_cs_count        (out_sck_to_cs_count),
    .out_between_transfer_count (out_between_transfer_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Convert a delay in ns to prescaled clock cycles: round up, drop the
  // floor, clamp to 255.
  function automatic logic [7:0] ns_to_cycles(logic [31:0] ns, logic [31:0] pclk,
                                              logic [63:0] floor_cyc);
    logic [63:0] prod;
    logic [63:0] cyc;
    prod = 64'(pclk) * 64'(ns);
    cyc = prod / NSEC + ((prod % NSEC) != 0 ? 64'd1 : 64'd0);
    if (cyc < floor_cyc) cyc = floor_cyc;
    cyc = cyc - floor_cyc;
    if (cyc > 64'd255) cyc = 64'd255;
    return cyc[7:0];
  endfunction

  // Search exponents 7..0 for the fastest clock at or below the request.
  function automatic clk_setting_t best_setting(logic [31:0] req);
    clk_setting_t r;
    logic [63:0] best_f;
    logic [63:0] preq;
    logic [63:0] ratio;
    logic [63:0] f;
    logic [2:0]  best_e;
    logic [7:0]  best_d;
    logic [31:0] pclk;
    best_f = '0;
    best_e = '0;
    best_d = '0;
    for (int e = spds_pkg::PRESCALE_STEPS - 1; e >= 0; e--) begin
      // stop once even the undivided rate can no longer win
      if (64'(src_hz) / (64'd2 << e) < best_f) break;
      preq = 64'(req) << e;
      if (preq == 0) ratio = 64'd257;
      else ratio = (64'(src_hz) + preq - 64'd1) / preq;
      if (ratio < 2) ratio = 64'd2;
      ratio = ratio - 64'd2;
      if (ratio > 255) ratio = 64'd255;
      f = 64'(src_hz) / ((ratio + 64'd2) << e);
      if (f >= best_f && f <= 64'(req)) begin
        best_f = f;
        best_e = 3'(e);
        best_d = ratio[7:0];
      end
    end
    pclk = src_hz >> best_e;
    r.ex = best_e;
    r.dvd = best_d;
    r.freq = best_f[30:0];
    r.cs_sck = ns_to_cycles(cs_sck_ns, pclk, 64'd1);
    r.sck_cs = ns_to_cycles(sck_cs_ns, pclk, 64'd1);
    r.gap = ns_to_cycles(gap_ns, pclk, 64'd2);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Push the expectation at the accepting edge, check results as they strobe.
  always @(posedge clk) begin
    clk_setting_t want;
    if (rst_n) begin
      if (start && !busy)
        pending_settings.push_back(next_has_known ? next_known
                                                  : best_setting(in_desired_freq));
      if (out_valid) begin
        if (pending_settings.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          mismatches++;
        end else begin
          want = pending_settings.pop_front();
          if (out_prescale_exp !== want.ex)
            report_mismatch("prescale_exp", 32'(out_prescale_exp), 32'(want.ex));
          if (out_sck_divider !== want.dvd)
            report_mismatch("sck_divider", 32'(out_sck_divider), 32'(want.dvd));
          if (out_achieved_freq !== want.freq)
            report_mismatch("achieved_freq", 32'(out_achieved_freq), 32'(want.freq));
          if (out_cs_to_sck_count !== want.cs_sck)
            report_mismatch("cs_to_sck_count", 32'(out_cs_to_sck_count), 32'(want.cs_sck));
          if (out_sck_to_cs_count !== want.sck_cs)
            report_mismatch("sck_to_cs_count", 32'(out_sck_to_cs_count), 32'(want.sck_cs));
          if (out_between_transfer_count !== want.gap)
            report_mismatch("between_transfer_count", 32'(out_between_transfer_count),
                            32'(want.gap));
        end
      end
    end
  end

  // Watchdog: end the run after too long without any item moving.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Write one register and keep the shadow copy in step.
  task automatic write_reg(spds_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      spds_pkg::REG_SRC_CLK:  src_hz = val;
      spds_pkg::REG_CS_SCK:   cs_sck_ns = val;
      spds_pkg::REG_SCK_CS:   sck_cs_ns = val;
      spds_pkg::REG_XFER_GAP: gap_ns = val;
      default: ;
    endcase
  endtask

  // Hold off until every expected item has come back, then reprogram.
  task automatic program_regs(logic [31:0] s, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c);
    @(negedge clk);
    start = 1'b0;
    wait (pending_settings.size() == 0);
    write_reg(spds_pkg::REG_SRC_CLK, s);
    write_reg(spds_pkg::REG_CS_SCK, a);
    write_reg(spds_pkg::REG_SCK_CS, b);
    write_reg(spds_pkg::REG_XFER_GAP, c);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one request; idle a cycle first at random, then hold start until taken.
  task automatic send_request(logic [31:0] req, bit has_known, clk_setting_t known);
    @(negedge clk);
    if (idle_enabled && $urandom_range(0, 99) < 19) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_desired_freq = req;
    next_has_known = has_known;
    next_known = known;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return $urandom_range(0, 200);
      2: return $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_request();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return src_hz / $urandom_range(2, 40000) + $urandom_range(0, 3);
      2: return src_hz >> $urandom_range(0, 20);
      3: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  directed_row_t dir_rows[$];

  initial begin
    directed_row_t row;
    clk_setting_t none;
    logic [31:0] s;
    none = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_desired_freq = '0;
    cfg_we = 1'b0;
    cfg_index = spds_pkg::REG_SRC_CLK;
    cfg_wdata = '0;
    src_hz = '0;
    cs_sck_ns = '0;
    sck_cs_ns = '0;
    gap_ns = '0;
    next_has_known = 1'b0;
    next_known = '0;
    mismatches = 0;
    idle_enabled = 1'b1;

    // After reset every register is zero: frequency and counts read zero,
    // and a zero request still lands on the largest divider.
    dir_rows.push_back('{0, 0, 0, 0, 0, 1,
                         '{3'd0, 8'd255, 31'd0, 8'd0, 8'd0, 8'd0}});
    dir_rows.push_back('{0, 0, 0, 0, MAX32, 1, '0});
    // Everything at its top: the undivided clock wins, delays saturate.
    dir_rows.push_back('{MAX32, MAX32, MAX32, MAX32, MAX32, 1,
                         '{3'd0, 8'd0, 31'h7FFF_FFFF, 8'd255, 8'd255, 8'd255}});
    // Zero request: nothing fits, delays run off the undivided clock.
    dir_rows.push_back('{MAX32, MAX32, MAX32, MAX32, 0, 1,
                         '{3'd0, 8'd0, 31'd0, 8'd255, 8'd255, 8'd255}});
    dir_rows.push_back('{MAX32, MAX32, MAX32, MAX32, 1, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 0, 1, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 1000000, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 25000000, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 50000000, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 49999999, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 390625, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 390000, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 100, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 1, 0, '0});
    dir_rows.push_back('{100000000, 0, 1, 2, 200000000, 0, '0});
    // One hertz source: every candidate is 0 Hz, ties go low.
    dir_rows.push_back('{1, 5, 5, 5, 1, 0, '0});
    // Zero source clock: everything reads zero whatever the delays.
    dir_rows.push_back('{0, 1000, 2000, 3000, 12345, 1, '0});
    dir_rows.push_back('{0, MAX32, MAX32, MAX32, MAX32, 1, '0});
    dir_rows.push_back('{48000000, 20, 20, 40, 1000000, 0, '0});
    dir_rows.push_back('{48000000, 20, 20, 40, 3000000, 0, '0});
    dir_rows.push_back('{48000000, 20, 20, 40, 187500, 0, '0});
    dir_rows.push_back('{48000000, 20, 20, 40, 32'h8000_0000, 0, '0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; reprogram only when a row changes the registers.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.src != src_hz || row.d_cs_sck != cs_sck_ns || row.d_sck_cs != sck_cs_ns ||
          row.d_gap != gap_ns)
        program_regs(row.src, row.d_cs_sck, row.d_sck_cs, row.d_gap);
      send_request(row.req, row.has_known, row.known);
    end

    // Random phases, each with its own register setting; phase 2 never idles.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0: s = $urandom_range(0, 1000);
        1: s = $urandom_range(1000000, 200000000);
        2: s = $urandom;
        3: s = MAX32;
        default: s = $urandom_range(1000000, 1000000000);
      endcase
      program_regs(s, rand_delay(), rand_delay(), rand_delay());
      idle_enabled = (ph != 2);
      repeat (80) send_request(rand_request(), 1'b0, none);
    end

    @(negedge clk);
    start = 1'b0;
    wait (pending_settings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
src/spds_pkg.sv
src/spds_div_cell.sv
src/sck_prescaler_divider_search.sv
tb/sck_prescaler_divider_search_tb.sv
